>>> sv/pid_position_controller_core_defines.svh
// Assertion macros for the PID position controller RTL.
// Used by pid_position_controller_core.sv; no other dependencies.
`ifndef PID_POSITION_CONTROLLER_CORE_DEFINES_SVH
`define PID_POSITION_CONTROLLER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PIDPC_ASSERT_HOLDS(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidpc assertion failed");
`define PIDPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidpc assertion failed");
`else
`define PIDPC_ASSERT_HOLDS(lbl, ante, cons)
`define PIDPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> sv/pidpc_pkg.sv
// Shared types, codes and saturation helpers for the PID position controller.
// No dependencies; used by pid_position_controller_core and pidpc_cfg.
package pidpc_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OP,
        ST_FMUL,
        ST_FADD,
        ST_ERR,
        ST_IMUL,
        ST_IACC,
        ST_DMUL,
        ST_DACC,
        ST_PMUL,
        ST_PACC,
        ST_CLAMP,
        ST_OUT
    } state_t;

    localparam logic [2:0] OP_COMPUTE  = 3'd0;
    localparam logic [2:0] OP_MANUAL   = 3'd1;
    localparam logic [2:0] OP_PAUSE    = 3'd2;
    localparam logic [2:0] OP_BUMPLESS = 3'd3;
    localparam logic [2:0] OP_RESTART  = 3'd4;

    localparam logic [2:0] REG_KP          = 3'd0;
    localparam logic [2:0] REG_KI_DT       = 3'd1;
    localparam logic [2:0] REG_KD_DT       = 3'd2;
    localparam logic [2:0] REG_OUT_LO      = 3'd3;
    localparam logic [2:0] REG_OUT_HI      = 3'd4;
    localparam logic [2:0] REG_INTEG_BOUND = 3'd5;
    localparam logic [2:0] REG_DEADBAND    = 3'd6;
    localparam logic [2:0] REG_FILTER_COEF = 3'd7;

    localparam logic signed [31:0] OUT_MIN_RESET = -32'sd6553600;
    localparam logic signed [31:0] OUT_MAX_RESET = 32'sd6553600;

    typedef struct packed {
        logic signed [31:0] kp;
        logic signed [31:0] ki_dt;
        logic signed [31:0] kd_dt;
        logic signed [31:0] out_lo;
        logic signed [31:0] out_hi;
        logic [30:0]        integ_bound;
        logic [30:0]        deadband;
        logic [16:0]        filter_coef;
    } cfg_t;

    // saturate a 34-bit sum to 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -34'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Q16.16 product: floor(p / 65536), saturated to 32 bits
    function automatic logic signed [31:0] satq16(input logic signed [65:0] p);
        logic signed [49:0] t;
        logic signed [31:0] r;
        t = $signed(p[65:16]);
        if (t > 50'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (t < -50'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = t[31:0];
        return r;
    endfunction

    // when the limits are crossed, values below the low limit give the low limit, all others the high
    function automatic logic signed [31:0] clamp_out(input logic signed [33:0] v,
                                                     input logic signed [31:0] mn,
                                                     input logic signed [31:0] mx);
        logic signed [33:0] mn_x;
        logic signed [33:0] mx_x;
        logic signed [31:0] r;
        mn_x = 34'(mn);
        mx_x = 34'(mx);
        if (v < mn_x)
            r = mn;
        else if (v > mx_x)
            r = mx;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> sv/pid_position_controller_core.sv
// PID position controller, Q16.16. A compute steps through OP, FMUL, FADD, ERR, IMUL, IACC,
// DMUL, DACC, PMUL, PACC, CLAMP and OUT (FMUL/FADD only with the filter on, no DMUL on the
// first step); other ops go from OP to OUT. One item is in work at a time; OUT waits for
// the last result to be taken, and the next item is accepted the cycle after the result
// is loaded. The shared 33x33 multiplier is used up to four times per compute. Reset clears
// all state but its product and restores register defaults (output limits -100/+100).
`include "pid_position_controller_core_defines.svh"
module pid_position_controller_core (
    input  logic         clk,
    input  logic         rst_n,
    // config write port
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // measurement[31:0], setpoint[63:32], manual_value[95:64]
    input  logic [3:0]   s_tuser,   // op[2:0], inputs_finite[3]
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // control_output[31:0]
    output logic [1:0]   m_tuser    // held_fault[0], saturated[1]
);

    pidpc_pkg::cfg_t cfg;

    pidpc_pkg::state_t state_reg, state_next;

    logic [2:0]         op_reg, op_next;
    logic               finite_reg, finite_next;
    logic signed [31:0] meas_reg, meas_next;
    logic signed [31:0] sp_reg, sp_next;
    logic signed [31:0] manual_reg, manual_next;

    logic signed [31:0] filt_reg, filt_next;
    logic signed [31:0] prev_reg, prev_next;
    logic signed [31:0] integ_reg, integ_next;
    logic signed [31:0] last_reg, last_next;
    logic               primed_reg, primed_next;

    logic signed [31:0] err_reg, err_next;
    logic signed [31:0] diff_reg, diff_next;
    logic signed [31:0] iterm_reg, iterm_next;
    logic signed [31:0] dterm_reg, dterm_next;
    logic signed [33:0] sum_reg, sum_next;
    logic               fault_reg, fault_next;
    logic               sat_reg, sat_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_data_reg, out_data_next;
    logic               out_fault_reg, out_fault_next;
    logic               out_sat_reg, out_sat_next;

    logic               mac_en;
    logic signed [32:0] mac_a;
    logic signed [32:0] mac_b;
    logic signed [65:0] prod;

    logic signed [31:0] prod_q;
    logic               filt_on;
    logic signed [31:0] filt_upd;
    logic signed [31:0] err_raw;
    logic signed [32:0] db_x;
    logic               in_db;
    logic signed [31:0] diff_val;
    logic signed [31:0] integ_add;
    logic signed [33:0] lim_x;
    logic signed [33:0] integ_add_x;
    logic signed [31:0] integ_clamped;
    logic signed [31:0] clamp_res;
    logic               sat_now;
    logic               back_off;
    logic signed [31:0] integ_back;
    logic signed [31:0] man_clamp;
    logic signed [33:0] integ_x;
    logic               integ_in_bound;
    logic               out_at_limit;

    pidpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pidpc_mac u_mac (
        .clk  (clk),
        .en   (mac_en),
        .a    (mac_a),
        .b    (mac_b),
        .prod (prod)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        mac_en = 1'b1;
        case (state_reg)
            pidpc_pkg::ST_FMUL:
            begin
                mac_a = $signed({16'd0, cfg.filter_coef});
                mac_b = 33'(meas_reg) - 33'(filt_reg);
            end
            pidpc_pkg::ST_IMUL:
            begin
                mac_a = 33'(cfg.ki_dt);
                mac_b = 33'(err_reg);
            end
            pidpc_pkg::ST_DMUL:
            begin
                mac_a = 33'(cfg.kd_dt);
                mac_b = 33'(diff_reg);
            end
            pidpc_pkg::ST_PMUL:
            begin
                mac_a = 33'(cfg.kp);
                mac_b = 33'(err_reg);
            end
            default:
            begin
                mac_en = 1'b0;
                mac_a  = '0;
                mac_b  = '0;
            end
        endcase
    end

    assign prod_q   = pidpc_pkg::satq16(prod);
    assign filt_on  = primed_reg && !cfg.filter_coef[16] && (cfg.filter_coef[15:0] != 16'd0);
    assign filt_upd = pidpc_pkg::sat34(34'(filt_reg) + 34'(prod_q));

    assign err_raw  = pidpc_pkg::sat34(34'(sp_reg) - 34'(filt_reg));
    assign db_x     = $signed({2'b00, cfg.deadband});
    assign in_db    = (cfg.deadband != 31'd0) && (33'(err_raw) < db_x) && (33'(err_raw) > -db_x);
    assign diff_val = pidpc_pkg::sat34(34'(prev_reg) - 34'(filt_reg));

    assign integ_add   = pidpc_pkg::sat34(34'(integ_reg) + 34'(prod_q));
    assign lim_x       = $signed({3'b000, cfg.integ_bound});
    assign integ_add_x = 34'(integ_add);
    assign integ_x     = 34'(integ_reg);

    always_comb
    begin
        if (integ_add_x > lim_x)
            integ_clamped = lim_x[31:0];
        else if (integ_add_x < -lim_x)
            integ_clamped = 32'(-lim_x);
        else
            integ_clamped = integ_add;
    end

    assign clamp_res  = pidpc_pkg::clamp_out(sum_reg, cfg.out_lo, cfg.out_hi);
    assign sat_now    = sum_reg != 34'(clamp_res);
    // take back this step's integral increment when it drives further into the limit
    assign back_off   = ((sum_reg > 34'(cfg.out_hi)) && (integ_reg > 32'sd0)) ||
                        ((sum_reg < 34'(cfg.out_lo)) && (integ_reg < 32'sd0));
    assign integ_back = pidpc_pkg::sat34(34'(integ_reg) - 34'(iterm_reg));
    assign man_clamp  = pidpc_pkg::clamp_out(34'(manual_reg), cfg.out_lo, cfg.out_hi);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        finite_next    = finite_reg;
        meas_next      = meas_reg;
        sp_next        = sp_reg;
        manual_next    = manual_reg;
        filt_next      = filt_reg;
        prev_next      = prev_reg;
        integ_next     = integ_reg;
        last_next      = last_reg;
        primed_next    = primed_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        iterm_next     = iterm_reg;
        dterm_next     = dterm_reg;
        sum_next       = sum_reg;
        fault_next     = fault_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_fault_next = out_fault_reg;
        out_sat_next   = out_sat_reg;
        s_tready       = 1'b0;

        case (state_reg)
            pidpc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next     = s_tuser[2:0];
                    finite_next = s_tuser[3];
                    meas_next   = $signed(s_tdata[31:0]);
                    sp_next     = $signed(s_tdata[63:32]);
                    manual_next = $signed(s_tdata[95:64]);
                    fault_next  = 1'b0;
                    sat_next    = 1'b0;
                    state_next  = pidpc_pkg::ST_OP;
                end
            end
            pidpc_pkg::ST_OP:
            begin
                state_next = pidpc_pkg::ST_OUT;
                case (op_reg)
                    pidpc_pkg::OP_COMPUTE:
                    begin
                        if (!finite_reg)
                            fault_next = 1'b1;
                        else if (filt_on)
                            state_next = pidpc_pkg::ST_FMUL;
                        else
                        begin
                            filt_next  = meas_reg;
                            state_next = pidpc_pkg::ST_ERR;
                        end
                    end
                    pidpc_pkg::OP_MANUAL:
                    begin
                        last_next  = man_clamp;
                        integ_next = man_clamp;
                    end
                    pidpc_pkg::OP_PAUSE:
                    begin
                        integ_next = last_reg;
                    end
                    pidpc_pkg::OP_BUMPLESS:
                    begin
                        integ_next  = last_reg;
                        primed_next = 1'b0;
                    end
                    pidpc_pkg::OP_RESTART:
                    begin
                        integ_next  = '0;
                        primed_next = 1'b0;
                    end
                    default:
                    begin
                        integ_next = integ_reg;
                    end
                endcase
            end
            pidpc_pkg::ST_FMUL:
            begin
                state_next = pidpc_pkg::ST_FADD;
            end
            pidpc_pkg::ST_FADD:
            begin
                filt_next  = filt_upd;
                state_next = pidpc_pkg::ST_ERR;
            end
            pidpc_pkg::ST_ERR:
            begin
                err_next   = in_db ? 32'sd0 : err_raw;
                diff_next  = diff_val;
                prev_next  = filt_reg;
                state_next = pidpc_pkg::ST_IMUL;
            end
            pidpc_pkg::ST_IMUL:
            begin
                state_next = pidpc_pkg::ST_IACC;
            end
            pidpc_pkg::ST_IACC:
            begin
                iterm_next = prod_q;
                integ_next = integ_clamped;
                state_next = primed_reg ? pidpc_pkg::ST_DMUL : pidpc_pkg::ST_DACC;
            end
            pidpc_pkg::ST_DMUL:
            begin
                state_next = pidpc_pkg::ST_DACC;
            end
            pidpc_pkg::ST_DACC:
            begin
                // no derivative on the first step after reset, bumpless or restart
                dterm_next  = primed_reg ? prod_q : 32'sd0;
                primed_next = 1'b1;
                state_next  = pidpc_pkg::ST_PMUL;
            end
            pidpc_pkg::ST_PMUL:
            begin
                state_next = pidpc_pkg::ST_PACC;
            end
            pidpc_pkg::ST_PACC:
            begin
                sum_next   = 34'(prod_q) + 34'(integ_reg) + 34'(dterm_reg);
                state_next = pidpc_pkg::ST_CLAMP;
            end
            pidpc_pkg::ST_CLAMP:
            begin
                last_next = clamp_res;
                sat_next  = sat_now;
                if (sat_now && back_off)
                    integ_next = integ_back;
                state_next = pidpc_pkg::ST_OUT;
            end
            pidpc_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = last_reg;
                    out_fault_next = fault_reg;
                    out_sat_next   = sat_reg;
                    state_next     = pidpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pidpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pidpc_pkg::ST_IDLE;
            op_reg        <= '0;
            finite_reg    <= 1'b0;
            meas_reg      <= '0;
            sp_reg        <= '0;
            manual_reg    <= '0;
            filt_reg      <= '0;
            prev_reg      <= '0;
            integ_reg     <= '0;
            last_reg      <= '0;
            primed_reg    <= 1'b0;
            err_reg       <= '0;
            diff_reg      <= '0;
            iterm_reg     <= '0;
            dterm_reg     <= '0;
            sum_reg       <= '0;
            fault_reg     <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_fault_reg <= 1'b0;
            out_sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            finite_reg    <= finite_next;
            meas_reg      <= meas_next;
            sp_reg        <= sp_next;
            manual_reg    <= manual_next;
            filt_reg      <= filt_next;
            prev_reg      <= prev_next;
            integ_reg     <= integ_next;
            last_reg      <= last_next;
            primed_reg    <= primed_next;
            err_reg       <= err_next;
            diff_reg      <= diff_next;
            iterm_reg     <= iterm_next;
            dterm_reg     <= dterm_next;
            sum_reg       <= sum_next;
            fault_reg     <= fault_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_fault_reg <= out_fault_next;
            out_sat_reg   <= out_sat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_sat_reg, out_fault_reg};

    assign integ_in_bound = (integ_x <= lim_x) && (integ_x >= -lim_x);
    assign out_at_limit   = (out_data_reg == cfg.out_lo) || (out_data_reg == cfg.out_hi);

    `PIDPC_ASSERT_NEXT(a_integ_bounded, state_reg == pidpc_pkg::ST_IACC, integ_in_bound)
    `PIDPC_ASSERT_HOLDS(a_sat_at_limit, out_valid_reg && out_sat_reg, out_at_limit)
    `PIDPC_ASSERT_HOLDS(a_fault_excl_sat, out_valid_reg && out_fault_reg, !out_sat_reg)

endmodule

>>> sv/pidpc_cfg.sv
// Configuration register file of the PID position controller.
// Depends on pidpc_pkg (cfg_t, register index codes).
module pidpc_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_addr,
    input  logic [31:0]       cfg_wdata,
    output pidpc_pkg::cfg_t   cfg
);

    pidpc_pkg::cfg_t cfg_reg;
    pidpc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                pidpc_pkg::REG_KP:          cfg_next.kp = $signed(cfg_wdata);
                pidpc_pkg::REG_KI_DT:       cfg_next.ki_dt = $signed(cfg_wdata);
                pidpc_pkg::REG_KD_DT:       cfg_next.kd_dt = $signed(cfg_wdata);
                pidpc_pkg::REG_OUT_LO:      cfg_next.out_lo = $signed(cfg_wdata);
                pidpc_pkg::REG_OUT_HI:      cfg_next.out_hi = $signed(cfg_wdata);
                pidpc_pkg::REG_INTEG_BOUND: cfg_next.integ_bound = cfg_wdata[30:0];
                pidpc_pkg::REG_DEADBAND:    cfg_next.deadband = cfg_wdata[30:0];
                pidpc_pkg::REG_FILTER_COEF: cfg_next.filter_coef = cfg_wdata[16:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp          <= '0;
            cfg_reg.ki_dt       <= '0;
            cfg_reg.kd_dt       <= '0;
            cfg_reg.out_lo      <= pidpc_pkg::OUT_MIN_RESET;
            cfg_reg.out_hi      <= pidpc_pkg::OUT_MAX_RESET;
            cfg_reg.integ_bound <= '0;
            cfg_reg.deadband    <= '0;
            cfg_reg.filter_coef <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/pidpc_mac.sv
// Shared 33x33 signed multiplier with a registered product.
// No dependencies; operands are selected by the sequencer in the top level.
module pidpc_mac (
    input  logic                clk,
    input  logic                en,
    input  logic signed [32:0]  a,
    input  logic signed [32:0]  b,
    output logic signed [65:0]  prod
);

    logic signed [65:0] prod_reg;
    logic signed [65:0] prod_next;

    assign prod_next = en ? (66'(a) * 66'(b)) : prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule
